// File: sv/ste_pkg.sv
`timescale 1ns / 1ps
package ste_pkg;
	localparam int unsigned CAPACITY_DEF = 256;
	localparam int unsigned PAYLOAD_BITS_DEF = 32;
	localparam int unsigned KEY_W = 32;
	localparam int unsigned POS_W = 9;

	typedef enum logic [2:0] {
		CMD_SORTED_INS = 3'd0,
		CMD_INS_AT     = 3'd1,
		CMD_SET        = 3'd2,
		CMD_GET        = 3'd3,
		CMD_DELETE     = 3'd4,
		CMD_FIND       = 3'd5
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_PROBE_RD,
		ST_PROBE_CMP,
		ST_FIND_RD,
		ST_FIND_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_PUT,
		ST_GET_RD,
		ST_GET_OUT,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_DONE
	} state_t;
endpackage

// File: sv/ste_store.sv
`timescale 1ns / 1ps
module ste_store import ste_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF,
	localparam int unsigned AW = $clog2(CAPACITY)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [AW-1:0]           waddr,
	input  logic [KEY_W-1:0]        wkey,
	input  logic [PAYLOAD_BITS-1:0] wpay,
	input  logic [AW-1:0]           raddr,
	output logic [KEY_W-1:0]        rkey,
	output logic [PAYLOAD_BITS-1:0] rpay
);
	logic [KEY_W+PAYLOAD_BITS-1:0] mem [CAPACITY];
	logic [KEY_W+PAYLOAD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wkey, wpay};
		end
		rdata_q <= mem[raddr];
	end

	assign rkey = rdata_q[KEY_W+PAYLOAD_BITS-1:PAYLOAD_BITS];
	assign rpay = rdata_q[PAYLOAD_BITS-1:0];
endmodule

// File: sv/sorted_table_engine.sv
`timescale 1ns / 1ps
// Channel   | Direction | Signals
// command   | in        | start, busy, cmd, key, payload, position, del_count
// result    | out       | done, ok, index, key_out, payload_out, entries_now
// config    | in        | cfg_valid, cfg_ready, cfg_data (sorted_mode)
// Find and sorted insert run a binary search over the entries; inserts and
// deletes move entries one at a time, all on the single entry memory.
// Reset clears the count and sorted_mode; entries are undefined until written.
// Results show for one cycle on done; the receiver cannot stall.
module sorted_table_engine import ste_pkg::*; #(
	parameter int unsigned CAPACITY = CAPACITY_DEF,
	parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              cmd,
	input  logic [KEY_W-1:0]        key,
	input  logic [PAYLOAD_BITS-1:0] payload,
	input  logic [POS_W-1:0]        position,
	input  logic [POS_W-1:0]        del_count,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic                    cfg_data,
	output logic                    done,
	output logic                    ok,
	output logic [7:0]              index,
	output logic [KEY_W-1:0]        key_out,
	output logic [PAYLOAD_BITS-1:0] payload_out,
	output logic [POS_W-1:0]        entries_now
);
	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned WW = (CW + 1 > POS_W + 1) ? CW + 1 : POS_W + 1;

	state_t state_q, state_d;
	logic [2:0]              cmd_q;
	logic [KEY_W-1:0]        key_q;
	logic [PAYLOAD_BITS-1:0] pay_q;
	logic [WW-1:0]           pos_q, cnt_q;
	logic [WW-1:0]           used_q;
	logic                    sorted_q;
	logic [WW-1:0]           i_q, step_q, t_q, ptr_q;
	logic                    ok_q;
	logic [7:0]              idx_q;
	logic [KEY_W-1:0]        kout_q;
	logic [PAYLOAD_BITS-1:0] pout_q;

	logic                    we;
	logic [AW-1:0]           waddr, raddr;
	logic [KEY_W-1:0]        wkey, rkey;
	logic [PAYLOAD_BITS-1:0] wpay, rpay;

	ste_store #(.CAPACITY(CAPACITY), .PAYLOAD_BITS(PAYLOAD_BITS)) u_store (
		.clk, .we, .waddr, .wkey, .wpay, .raddr, .rkey, .rpay
	);

	localparam logic [WW-1:0] CAP = WW'(CAPACITY);

	logic [WW-1:0] probe_t, i_next;
	logic          find_mode, go_next, hit;
	logic          full;

	assign full = (used_q >= CAP);
	assign find_mode = (cmd_q == CMD_FIND);
	// probe target: min(used-1, i+step)
	assign probe_t = ((i_q + step_q) < (used_q - 1'b1)) ? (i_q + step_q) : (used_q - 1'b1);

	always_comb begin
		hit = 1'b0;
		i_next = i_q;
		if (find_mode && key_q == rkey) begin
			i_next = t_q;
			hit = 1'b1;
		end
		if (find_mode ? (key_q > rkey) : (key_q >= rkey)) begin
			i_next = t_q + 1'b1;
		end
		go_next = !hit && (i_next != used_q + 1'b1) && (step_q != '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_DONE;
				case (cmd_q)
					CMD_SORTED_INS: begin
						if (!full) state_d = (sorted_q && used_q != '0) ? ST_PROBE_RD : ST_PUT;
					end
					CMD_INS_AT: begin
						if (!full && pos_q <= used_q) state_d = ST_SHIFT_RD;
					end
					CMD_SET: begin
						if (pos_q < used_q) state_d = ST_PUT;
						else if (pos_q == used_q && !full) state_d = ST_PUT;
					end
					CMD_GET: begin
						if (pos_q < used_q) state_d = ST_GET_RD;
					end
					CMD_DELETE: begin
						if (pos_q + cnt_q <= used_q) state_d = ST_DEL_RD;
					end
					CMD_FIND: begin
						if (sorted_q && used_q != '0) state_d = ST_PROBE_RD;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_PROBE_RD:  state_d = ST_PROBE_CMP;
			ST_PROBE_CMP: begin
				if (go_next) state_d = ST_PROBE_RD;
				else if (find_mode) state_d = ST_FIND_RD;
				else state_d = ST_SHIFT_RD;
			end
			ST_FIND_RD:  state_d = ST_FIND_CMP;
			ST_FIND_CMP: state_d = ST_DONE;
			ST_SHIFT_RD: state_d = (ptr_q > pos_q) ? ST_SHIFT_WR : ST_PUT;
			ST_SHIFT_WR: state_d = ST_SHIFT_RD;
			ST_PUT:      state_d = ST_DONE;
			ST_GET_RD:   state_d = ST_GET_OUT;
			ST_GET_OUT:  state_d = ST_DONE;
			ST_DEL_RD:   state_d = (ptr_q + cnt_q < used_q) ? ST_DEL_WR : ST_DONE;
			ST_DEL_WR:   state_d = ST_DEL_RD;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		we = 1'b0;
		waddr = AW'(pos_q);
		wkey = key_q;
		wpay = pay_q;
		raddr = AW'(t_q);
		unique case (state_q)
			ST_PROBE_RD: raddr = AW'(probe_t);
			ST_FIND_RD:  raddr = AW'(t_q);
			ST_SHIFT_RD: raddr = AW'(ptr_q - 1'b1);
			ST_SHIFT_WR: begin
				we = 1'b1;
				waddr = AW'(ptr_q);
				wkey = rkey;
				wpay = rpay;
			end
			ST_PUT:    we = 1'b1;
			ST_GET_RD: raddr = AW'(pos_q);
			ST_DEL_RD: raddr = AW'(ptr_q + cnt_q);
			ST_DEL_WR: begin
				we = 1'b1;
				waddr = AW'(ptr_q);
				wkey = rkey;
				wpay = rpay;
			end
			default: ;
		endcase
	end

	// grow the count on insert, or on a set that appends
	logic ins_grow_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_grow_q <= 1'b0;
		end else if (state_q == ST_DECIDE) begin
			ins_grow_q <= (cmd_q != CMD_SET) || (pos_q == used_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			sorted_q <= 1'b0;
			ok_q <= 1'b0;
			cmd_q <= '0;
			key_q <= '0;
			pay_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
			i_q <= '0;
			step_q <= '0;
			t_q <= '0;
			ptr_q <= '0;
			idx_q <= '0;
			kout_q <= '0;
			pout_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) sorted_q <= cfg_data;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						key_q <= key;
						pay_q <= payload;
						pos_q <= WW'(position);
						cnt_q <= WW'(del_count);
						idx_q <= '0;
						kout_q <= '0;
						pout_q <= '0;
					end
				end
				ST_DECIDE: begin
					ok_q <= 1'b0;
					i_q <= '0;
					step_q <= used_q >> 1;
					ptr_q <= (cmd_q == CMD_DELETE) ? pos_q : used_q;
					if (cmd_q == CMD_SORTED_INS) pos_q <= used_q;
				end
				ST_PROBE_RD: t_q <= probe_t;
				ST_PROBE_CMP: begin
					i_q <= i_next;
					step_q <= step_q >> 1;
					if (!go_next) begin
						pos_q <= i_next;
						t_q <= (i_next < used_q - 1'b1) ? i_next : (used_q - 1'b1);
					end
				end
				ST_FIND_CMP: begin
					if (rkey == key_q) begin
						ok_q <= 1'b1;
						idx_q <= t_q[7:0];
					end
				end
				ST_SHIFT_WR: ptr_q <= ptr_q - 1'b1;
				ST_PUT: begin
					ok_q <= 1'b1;
					idx_q <= pos_q[7:0];
					if (ins_grow_q) used_q <= used_q + 1'b1;
				end
				ST_GET_OUT: begin
					ok_q <= 1'b1;
					kout_q <= rkey;
					pout_q <= rpay;
				end
				ST_DEL_RD: begin
					if (ptr_q + cnt_q >= used_q) begin
						ok_q <= 1'b1;
						used_q <= used_q - cnt_q;
					end
				end
				ST_DEL_WR: ptr_q <= ptr_q + 1'b1;
				default: ;
			endcase
		end
	end

	logic [WW-1:0] count_out;
	assign count_out = used_q;

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign ok = ok_q;
	assign index = ok_q ? idx_q : 8'd0;
	assign key_out = ok_q ? kout_q : '0;
	assign payload_out = ok_q ? pout_q : '0;
	assign entries_now = POS_W'(count_out);

	assert property (@(posedge clk) disable iff (!arst_n) used_q <= CAP)
		else $error("count above capacity");
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("busy after result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command not taken");
	assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == ST_PUT || state_q == ST_SHIFT_WR || state_q == ST_DEL_WR))
		else $error("stray write");
endmodule
